// ----- hw/rtl/ptsm_pkg.sv -----
// Shared types, constants and a helper function of the pulse train similarity matcher.
package ptsm_pkg;

    localparam int MAX_PULSES_DEF = 256;
    localparam int NUM_W          = 24;
    localparam int DEN_W          = 17;
    localparam int Q_W            = 7;

    localparam logic [6:0] THR_RESET      = 7'd80;
    localparam logic [6:0] SIGN_MIN_RESET = 7'd90;
    localparam logic [6:0] CNT_MIN_RESET  = 7'd70;
    localparam logic [8:0] USEFUL_RESET   = 9'd8;

    typedef enum logic [1:0] {
        CFG_MATCH_THRESHOLD = 2'd0,
        CFG_MIN_SIGN        = 2'd1,
        CFG_MIN_COUNT       = 2'd2,
        CFG_MIN_USEFUL      = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SETUP,
        S_READ,
        S_PAIR,
        S_DIV_GO,
        S_DIV_WAIT,
        S_BEST,
        S_NEXT,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        DIV_PAIR,
        DIV_CNT,
        DIV_TIM,
        DIV_SGN
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     clear_best;
        logic     shift_first;
        logic     shift_adv;
        logic     pair_init;
        logic     pair;
        logic     skip;
        logic     div_start;
        div_sel_t div_sel;
        logic     div_store;
        logic     best_upd;
        logic     finish;
    } cmd_t;

    typedef struct packed {
        logic global_ok;
        logic shift_ok;
        logic pair_zero;
        logic pair_last;
        logic div_done;
        logic shift_last;
        logic better;
        logic out_busy;
    } sts_t;

    // Magnitude of a 16-bit two's complement duration.
    function automatic logic [16:0] mag16(input logic [15:0] v);
        logic [16:0] m;
        if (v[15])
            m = 17'h10000 - {1'b0, v};
        else
            m = {1'b0, v};
        return m;
    endfunction

endpackage

// ----- hw/rtl/ptsm_ram.sv -----
// Generic single write port, single read port RAM with registered read.
module ptsm_ram
    import ptsm_pkg::*;
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = MAX_PULSES_DEF
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/ptsm_div.sv -----
// Restoring divider, one quotient bit per cycle, for quotients below 128.
module ptsm_div
    import ptsm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [Q_W-1:0]   quo
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [2:0]       k_reg, k_next;
    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [Q_W-1:0]   quo_reg, quo_next;
    logic [NUM_W-1:0] trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg   <= k_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    always_comb
    begin
        trial     = NUM_W'(den_reg) << k_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        k_next    = k_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            k_next    = 3'd6;
            rem_next  = num;
            den_next  = den;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            // take the shifted divisor out where it fits
            if (rem_reg >= trial)
            begin
                rem_next        = rem_reg - trial;
                quo_next[k_reg] = 1'b1;
            end
            if (k_reg == 3'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                k_next = k_reg - 3'd1;
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ----- hw/rtl/ptsm_dp.sv -----
// Datapath: pulse stores, lengths, configuration, shift scoring and result register.
module ptsm_dp
    import ptsm_pkg::*;
#(
    parameter int MAX_PULSES = MAX_PULSES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic        cfg_valid,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    input  logic        command,
    input  logic [15:0] pulse,
    input  logic        last,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [6:0]  similarity,
    output logic [6:0]  timing_similarity,
    output logic [6:0]  count_similarity,
    output logic [6:0]  sign_agreement,
    output logic [8:0]  compared_pulses,
    output logic        matched
);

    localparam int LW  = $clog2(MAX_PULSES + 1);
    localparam int AW  = $clog2(MAX_PULSES);
    localparam int TSW = $clog2(100 * MAX_PULSES + 1);

    logic [LW-1:0]  ll_reg, il_reg, i_reg, smatch_reg;
    logic           closed_reg;
    logic [6:0]     thr_reg, sign_min_reg, cnt_min_reg;
    logic [8:0]     useful_reg;
    logic [2:0]     k_reg;
    logic [TSW-1:0] tsum_reg;
    logic [6:0]     cnt_reg, tim_reg, sgn_reg, sim_reg;
    logic [6:0]     best_sim_reg, best_tim_reg, best_cnt_reg, best_sgn_reg;
    logic [LW-1:0]  best_cmp_reg;
    logic           best_match_reg;
    logic           rv_reg;
    logic [6:0]     o_sim_reg, o_tim_reg, o_cnt_reg, o_sgn_reg;
    logic [8:0]     o_cmp_reg;
    logic           o_match_reg;

    logic [LW-1:0]  lwa, ls, is, lr, ir, cmp, short_len, long_len;
    logic [LW-1:0]  l_raddr, i_raddr;
    logic           l_we, i_we;
    logic [15:0]    l_rdata, i_rdata, cmp_w;
    logic [16:0]    ma, mb, big, diff;
    logic [NUM_W-1:0] d_num;
    logic [DEN_W-1:0] d_den;
    logic           d_done;
    logic [Q_W-1:0] d_quo;
    logic [13:0]    mix;
    logic [26:0]    mix_q;
    logic [6:0]     sim_w;

    // learned write address restarts when a closed train is reopened
    assign lwa  = closed_reg ? '0 : ll_reg;
    assign l_we = cmd.load && !command && (32'(lwa) < MAX_PULSES);
    assign i_we = cmd.load && command && (32'(il_reg) < MAX_PULSES);

    assign ls        = (k_reg < 3'd2) ? LW'(3'd2 - k_reg) : '0;
    assign is        = (k_reg > 3'd2) ? LW'(k_reg - 3'd2) : '0;
    assign lr        = ll_reg - ls;
    assign ir        = il_reg - is;
    assign cmp       = (lr < ir) ? lr : ir;
    assign short_len = (ll_reg < il_reg) ? ll_reg : il_reg;
    assign long_len  = (ll_reg > il_reg) ? ll_reg : il_reg;

    assign l_raddr = LW'(ls + i_reg);
    assign i_raddr = LW'(is + i_reg);

    ptsm_ram #(.WIDTH(16), .DEPTH(MAX_PULSES)) u_learned (
        .clk   (clk),
        .we    (l_we),
        .waddr (lwa[AW-1:0]),
        .wdata (pulse),
        .raddr (l_raddr[AW-1:0]),
        .rdata (l_rdata)
    );

    ptsm_ram #(.WIDTH(16), .DEPTH(MAX_PULSES)) u_incoming (
        .clk   (clk),
        .we    (i_we),
        .waddr (il_reg[AW-1:0]),
        .wdata (pulse),
        .raddr (i_raddr[AW-1:0]),
        .rdata (i_rdata)
    );

    assign ma   = mag16(l_rdata);
    assign mb   = mag16(i_rdata);
    assign big  = (ma > mb) ? ma : mb;
    assign diff = (ma > mb) ? (ma - mb) : (mb - ma);

    // weighted score over 100 by reciprocal multiplication, exact below 43699
    assign mix   = 14'(tim_reg) * 14'd85 + 14'(cnt_reg) * 14'd15;
    assign mix_q = 27'(mix) * 27'd5243;
    assign sim_w = mix_q[25:19];

    always_comb
    begin
        case (cmd.div_sel)
            DIV_PAIR:
            begin
                d_num = NUM_W'(diff) * NUM_W'(100);
                d_den = big;
            end
            DIV_CNT:
            begin
                d_num = NUM_W'(short_len) * NUM_W'(100);
                d_den = DEN_W'(long_len);
            end
            DIV_TIM:
            begin
                d_num = NUM_W'(tsum_reg);
                d_den = DEN_W'(cmp);
            end
            DIV_SGN:
            begin
                d_num = NUM_W'(smatch_reg) * NUM_W'(100);
                d_den = DEN_W'(cmp);
            end
            default:
            begin
                d_num = '0;
                d_den = DEN_W'(1);
            end
        endcase
    end

    ptsm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (d_num),
        .den   (d_den),
        .done  (d_done),
        .quo   (d_quo)
    );

    always_comb
    begin
        sts.global_ok  = closed_reg && (ll_reg != '0) && (il_reg != '0)
                         && (16'(ll_reg) >= 16'(useful_reg))
                         && (16'(il_reg) >= 16'(useful_reg));
        sts.shift_ok   = (ls < ll_reg) && (is < il_reg) && (cmp != '0)
                         && (16'(cmp) >= 16'(useful_reg))
                         && (32'(cmp) * 32'd100 >= 32'(short_len) * 32'd90);
        sts.pair_zero  = (ma == '0) || (mb == '0);
        sts.pair_last  = (LW'(i_reg + LW'(1)) == cmp);
        sts.div_done   = d_done;
        sts.shift_last = (k_reg == 3'd4);
        sts.better     = (sim_reg > best_sim_reg);
        sts.out_busy   = rv_reg && result_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ll_reg       <= '0;
            il_reg       <= '0;
            closed_reg   <= 1'b0;
            thr_reg      <= THR_RESET;
            sign_min_reg <= SIGN_MIN_RESET;
            cnt_min_reg  <= CNT_MIN_RESET;
            useful_reg   <= USEFUL_RESET;
            rv_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_MATCH_THRESHOLD: thr_reg      <= cfg_data[6:0];
                    CFG_MIN_SIGN:        sign_min_reg <= cfg_data[6:0];
                    CFG_MIN_COUNT:       cnt_min_reg  <= cfg_data[6:0];
                    CFG_MIN_USEFUL:      useful_reg   <= cfg_data;
                    default:             thr_reg      <= thr_reg;
                endcase
            end
            if (cmd.load && !command)
            begin
                ll_reg     <= l_we ? LW'(lwa + LW'(1)) : lwa;
                closed_reg <= last;
            end
            if (i_we)
            begin
                il_reg <= LW'(il_reg + LW'(1));
            end
            if (cmd.finish)
            begin
                il_reg <= '0;
                rv_reg <= 1'b1;
            end
            else if (rv_reg && !result_stall)
            begin
                rv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.shift_first)
            k_reg <= 3'd0;
        else if (cmd.shift_adv)
            k_reg <= k_reg + 3'd1;

        if (cmd.pair_init)
        begin
            i_reg      <= '0;
            tsum_reg   <= '0;
            smatch_reg <= '0;
        end
        if (cmd.pair && (l_rdata[15] == i_rdata[15]))
            smatch_reg <= LW'(smatch_reg + LW'(1));
        if (cmd.skip)
            i_reg <= LW'(i_reg + LW'(1));

        if (cmd.div_store)
        begin
            case (cmd.div_sel)
                DIV_PAIR:
                begin
                    tsum_reg <= TSW'(tsum_reg + TSW'(7'd100 - d_quo));
                    i_reg    <= LW'(i_reg + LW'(1));
                end
                DIV_CNT: cnt_reg <= d_quo;
                DIV_TIM: tim_reg <= d_quo;
                DIV_SGN:
                begin
                    sgn_reg <= d_quo;
                    sim_reg <= sim_w;
                end
                default: sim_reg <= sim_reg;
            endcase
        end

        if (cmd.clear_best)
        begin
            best_sim_reg   <= '0;
            best_tim_reg   <= '0;
            best_cnt_reg   <= '0;
            best_sgn_reg   <= '0;
            best_cmp_reg   <= '0;
            best_match_reg <= 1'b0;
        end
        else if (cmd.best_upd)
        begin
            best_sim_reg   <= sim_reg;
            best_tim_reg   <= tim_reg;
            best_cnt_reg   <= cnt_reg;
            best_sgn_reg   <= sgn_reg;
            best_cmp_reg   <= cmp;
            best_match_reg <= (sim_reg >= thr_reg) && (sgn_reg >= sign_min_reg)
                              && (cnt_reg >= cnt_min_reg);
        end

        if (cmd.finish)
        begin
            o_sim_reg   <= best_sim_reg;
            o_tim_reg   <= best_tim_reg;
            o_cnt_reg   <= best_cnt_reg;
            o_sgn_reg   <= best_sgn_reg;
            o_cmp_reg   <= cmp_w[8:0];
            o_match_reg <= best_match_reg;
        end
    end

    assign cmp_w = 16'(best_cmp_reg);

    assign result_valid      = rv_reg;
    assign similarity        = o_sim_reg;
    assign timing_similarity = o_tim_reg;
    assign count_similarity  = o_cnt_reg;
    assign sign_agreement    = o_sgn_reg;
    assign compared_pulses   = o_cmp_reg;
    assign matched           = o_match_reg;

endmodule

// ----- hw/rtl/ptsm_ctrl.sv -----
// Controller: sequences loads, shifts, pair scoring, divisions and result hand-off.
module ptsm_ctrl
    import ptsm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic pulse_valid,
    input  logic command,
    input  logic last,
    output logic pulse_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t   state_reg, state_next;
    div_sel_t sel_reg, sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= DIV_PAIR;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        sel_next    = sel_reg;
        cmd         = '0;
        cmd.div_sel = sel_reg;
        pulse_stall = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (pulse_valid)
                begin
                    cmd.load = 1'b1;
                    if (command && last)
                        state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.clear_best  = 1'b1;
                cmd.shift_first = 1'b1;
                state_next = sts.global_ok ? S_SETUP : S_DONE;
            end
            S_SETUP:
            begin
                if (sts.shift_ok)
                begin
                    cmd.pair_init = 1'b1;
                    state_next    = S_READ;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_READ:
            begin
                state_next = S_PAIR;
            end
            S_PAIR:
            begin
                cmd.pair = 1'b1;
                if (sts.pair_zero)
                begin
                    cmd.skip = 1'b1;
                    if (sts.pair_last)
                    begin
                        sel_next   = DIV_CNT;
                        state_next = S_DIV_GO;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
                else
                begin
                    sel_next   = DIV_PAIR;
                    state_next = S_DIV_GO;
                end
            end
            S_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.div_store = 1'b1;
                    state_next    = S_DIV_GO;
                    case (sel_reg)
                        DIV_PAIR:
                        begin
                            if (sts.pair_last)
                                sel_next = DIV_CNT;
                            else
                                state_next = S_READ;
                        end
                        DIV_CNT: sel_next = DIV_TIM;
                        DIV_TIM: sel_next = DIV_SGN;
                        DIV_SGN: state_next = S_BEST;
                        default: state_next = S_BEST;
                    endcase
                end
            end
            S_BEST:
            begin
                cmd.best_upd = sts.better;
                state_next   = S_NEXT;
            end
            S_NEXT:
            begin
                if (sts.shift_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.shift_adv = 1'b1;
                    state_next    = S_SETUP;
                end
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/pulse_train_similarity_matcher.sv -----
// Top level of the pulse train similarity matcher: controller, datapath and ports.
//
// Pulse channel: pulse_valid/pulse_stall carry one request of command, pulse and
// last. Command 0 appends a pulse to the learned train, command 1 to the incoming
// train; pulses beyond MAX_PULSES are dropped, the last flag still counts.
// A learned pulse after a closed learned train starts a fresh learned train.
// Loads may follow back to back.
// An incoming pulse with last set starts a compare over shifts -2..+2; the input
// stalls until the result is placed in the output register. Each aligned pulse
// pair is read, paired and scored by the shared 7-step divider (a pair holding a
// zero duration skips the division); each usable shift then runs the count, timing
// and sign divisions and the best-result update, while a discarded shift goes
// straight to the next; a too-short or open train goes to the result directly.
// Result channel: result_valid/result_stall carry one request per compare; the
// output register holds it while stalled, and loads go on meanwhile.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Write only while idle.
// Reset (rst_n, asynchronous) empties both trains, opens the learned train and
// restores the thresholds 80/90/70 and minimum pulses 8.
module pulse_train_similarity_matcher
    import ptsm_pkg::*;
#(
    parameter int MAX_PULSES = MAX_PULSES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pulse_valid,
    output logic        pulse_stall,
    input  logic        command,
    input  logic [15:0] pulse,
    input  logic        last,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [6:0]  similarity,
    output logic [6:0]  timing_similarity,
    output logic [6:0]  count_similarity,
    output logic [6:0]  sign_agreement,
    output logic [8:0]  compared_pulses,
    output logic        matched,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    cmd_t cmd;
    sts_t sts;

    // registers accept a write on any cycle
    assign cfg_ready = 1'b1;

    ptsm_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .pulse_valid (pulse_valid),
        .command     (command),
        .last        (last),
        .pulse_stall (pulse_stall),
        .sts         (sts),
        .cmd         (cmd)
    );

    ptsm_dp #(.MAX_PULSES(MAX_PULSES)) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .cfg_valid         (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .command           (command),
        .pulse             (pulse),
        .last              (last),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .similarity        (similarity),
        .timing_similarity (timing_similarity),
        .count_similarity  (count_similarity),
        .sign_agreement    (sign_agreement),
        .compared_pulses   (compared_pulses),
        .matched           (matched)
    );

endmodule
